// File: design/wwmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwmr_pkg
// shared constants and types for the windowed waveform misfit residual core
// ----------------------------------------------------------------------------
package wwmr_pkg;

    localparam int DefMaxSamples = 4096;
    localparam int IdxW          = 13;
    localparam int DiffW         = 17;
    localparam int EnergyW       = 43;
    localparam int MisfitW       = 45;
    localparam int IntervalW     = 16;
    localparam int ResW          = 32;
    // denominator energy*interval
    localparam int DenW          = EnergyW + IntervalW;
    // dividend magnitude << 47
    localparam int NumW          = 64;
    localparam int QuotW         = 64;

    localparam logic [1:0] RegFirst    = 2'd0;
    localparam logic [1:0] RegLast     = 2'd1;
    localparam logic [1:0] RegCount    = 2'd2;
    localparam logic [1:0] RegInterval = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // apply a load transaction
        logic rd;         // issue store read for drain
        logic mul;        // capture denominator product
        logic div_start;  // initialise divider
        logic div_step;   // one radix-16 divider step
        logic finish;     // form result
        logic clear;      // end of trace
    } wwmr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic drain_last;
    } wwmr_stat_t;

endpackage : wwmr_pkg
`default_nettype wire

// File: design/windowed_waveform_misfit_residual_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_waveform_misfit_residual_core
// windowed l2 waveform misfit with adjoint source residuals
// ----------------------------------------------------------------------------
// A load transaction (operation 0) stores one observed / synthetic pair; a
// drain transaction (operation 1) runs from its acceptance to the next
// acceptance through the accept cycle, which issues the store read and the
// energy*interval multiply, a read state that initialises the divider,
// sixteen radix-16 steps of the 64-bit restoring divider, a state that waits
// for the output register to be free, and a result state into the output
// register. The wait state stretches for as long as a previous result has
// not been taken. The divider sets the drain rate. The next transaction is
// accepted while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
module windowed_waveform_misfit_residual_core #(
    parameter int MaxSamples = wwmr_pkg::DefMaxSamples
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic signed [15:0] observed,
    input  wire logic signed [15:0] synthetic,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      residual,
    output logic [44:0]             misfit,
    output logic                    last,
    output logic                    zero_energy
);
    import wwmr_pkg::*;

    logic [12:0] first_reg, last_reg, count_reg;
    logic [15:0] interval_reg;

    assign pready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= 13'd1;
            last_reg     <= 13'd4096;
            count_reg    <= 13'd4096;
            interval_reg <= 16'hffff;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                RegFirst:    first_reg    <= pwdata[12:0];
                RegLast:     last_reg     <= pwdata[12:0];
                RegCount:    count_reg    <= pwdata[12:0];
                RegInterval: interval_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[3:2])
            RegFirst:    prdata = {19'd0, first_reg};
            RegLast:     prdata = {19'd0, last_reg};
            RegCount:    prdata = {19'd0, count_reg};
            RegInterval: prdata = {16'd0, interval_reg};
            default:     prdata = '0;
        endcase
    end

    wwmr_cmd_t  cmd;
    wwmr_stat_t stat;

    wwmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wwmr_datapath #(.MaxSamples(MaxSamples)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_first    (first_reg),
        .cfg_last     (last_reg),
        .cfg_count    (count_reg),
        .cfg_interval (interval_reg),
        .observed     (observed),
        .synthetic    (synthetic),
        .residual     (residual),
        .misfit       (misfit),
        .last         (last),
        .zero_energy  (zero_energy)
    );
endmodule : windowed_waveform_misfit_residual_core
`default_nettype wire

// File: design/wwmr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwmr_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module wwmr_ram #(
    parameter int Width = 17,
    parameter int Depth = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule : wwmr_ram
`default_nettype wire

// File: design/wwmr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwmr_datapath
// sums, index counters, difference store and radix-16 restoring divider
// ----------------------------------------------------------------------------
module wwmr_datapath #(
    parameter int MaxSamples = wwmr_pkg::DefMaxSamples
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wwmr_pkg::wwmr_cmd_t    cmd,
    output wwmr_pkg::wwmr_stat_t        stat,
    input  wire logic [12:0]            cfg_first,
    input  wire logic [12:0]            cfg_last,
    input  wire logic [12:0]            cfg_count,
    input  wire logic [15:0]            cfg_interval,
    input  wire logic signed [15:0]     observed,
    input  wire logic signed [15:0]     synthetic,
    output logic signed [31:0]          residual,
    output logic [44:0]                 misfit,
    output logic                        last,
    output logic                        zero_energy
);
    import wwmr_pkg::*;

    localparam int AddrW = $clog2(MaxSamples);
    localparam int CntW  = AddrW + 1;
    // load position runs one past the count
    localparam int PosW  = IdxW + 1;
    localparam int CmpW  = CntW + PosW;

    logic [EnergyW-1:0] energy_reg;
    logic [MisfitW-1:0] misfit_reg;
    logic [PosW-1:0]    load_idx_reg;
    logic [IdxW-1:0]    drain_idx_reg;

    // effective bounds
    logic [CntW-1:0] count;
    logic [IdxW-1:0] count13, first13, end13;
    always_comb
    begin
        if (cfg_count == '0)
            count = CntW'(1);
        else if (CmpW'(cfg_count) > CmpW'(MaxSamples))
            count = CntW'(MaxSamples);
        else
            count = CntW'(cfg_count);
        count13 = IdxW'(count);
        first13 = (cfg_first == '0) ? IdxW'(1) : cfg_first;
        end13   = (cfg_last < count13) ? cfg_last : count13;
    end

    logic load_ok, load_win, drain_win;
    assign load_ok   = (CmpW'(load_idx_reg) <= CmpW'(count));
    assign load_win  = ({1'b0, first13} <= load_idx_reg) && (load_idx_reg <= {1'b0, end13});
    assign drain_win = (drain_idx_reg >= first13) && (drain_idx_reg <= end13);
    assign stat.drain_last = (CmpW'(drain_idx_reg) >= CmpW'(count));

    // load arithmetic
    logic signed [DiffW-1:0] diff;
    logic [31:0]             obs_sq;
    logic [33:0]             diff_sq;
    logic [EnergyW:0]        e_sum;
    logic [MisfitW:0]        m_sum;
    assign diff    = DiffW'(synthetic) - DiffW'(observed);
    assign obs_sq  = 32'(observed * observed);
    assign diff_sq = 34'(diff * diff);
    assign e_sum   = {1'b0, energy_reg} + (EnergyW+1)'(obs_sq);
    assign m_sum   = {1'b0, misfit_reg} + (MisfitW+1)'(diff_sq);

    // difference store
    logic [AddrW-1:0] ram_addr;
    logic [DiffW-1:0] ram_rdata;
    logic             ram_we;
    assign ram_we   = cmd.load && load_ok && load_win;
    assign ram_addr = cmd.load ? AddrW'(load_idx_reg - PosW'(1))
                               : AddrW'(drain_idx_reg - 13'd1);

    wwmr_ram #(.Width(DiffW), .Depth(MaxSamples)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (diff),
        .rdata (ram_rdata)
    );

    // drain pipeline registers
    logic                 win_reg;
    logic                 lastf_reg;
    logic [DenW-1:0]      den_reg;
    logic [NumW-1:0]      num_reg;
    logic [DenW+4:0]      rem_reg;
    logic                 neg_reg;
    logic                 zd_reg;

    // radix-16 step: shift in four dividend bits and four quotient bits
    logic [DenW+4:0] r0, r1, r2, r3, r4;
    logic [3:0]      qd;
    logic [DenW+4:0] den_x;
    assign den_x = (DenW+5)'(den_reg);
    always_comb
    begin
        r0 = {rem_reg[DenW:0], num_reg[NumW-1]};
        qd[3] = (r0 >= den_x);
        r1 = qd[3] ? r0 - den_x : r0;
        r1 = {r1[DenW+3:0], num_reg[NumW-2]};
        qd[2] = (r1 >= den_x);
        r2 = qd[2] ? r1 - den_x : r1;
        r2 = {r2[DenW+3:0], num_reg[NumW-3]};
        qd[1] = (r2 >= den_x);
        r3 = qd[1] ? r2 - den_x : r2;
        r3 = {r3[DenW+3:0], num_reg[NumW-4]};
        qd[0] = (r3 >= den_x);
        r4 = qd[0] ? r3 - den_x : r3;
    end

    // residual saturation
    logic [31:0] res_val;
    always_comb
    begin
        if (!win_reg || zd_reg)
            res_val = '0;
        else if (neg_reg)
            res_val = (num_reg >= 64'h8000_0000) ? 32'h8000_0000
                                                 : 32'(32'd0 - num_reg[31:0]);
        else
            res_val = (num_reg > 64'h7fff_ffff) ? 32'h7fff_ffff : num_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg    <= '0;
            misfit_reg    <= '0;
            load_idx_reg  <= PosW'(1);
            drain_idx_reg <= IdxW'(1);
        end
        else if (cmd.load)
        begin
            if (load_ok)
            begin
                load_idx_reg <= load_idx_reg + PosW'(1);
                if (load_win)
                begin
                    energy_reg <= e_sum[EnergyW] ? '1 : e_sum[EnergyW-1:0];
                    misfit_reg <= m_sum[MisfitW] ? '1 : m_sum[MisfitW-1:0];
                end
            end
        end
        else if (cmd.clear)
        begin
            energy_reg    <= '0;
            misfit_reg    <= '0;
            load_idx_reg  <= PosW'(1);
            drain_idx_reg <= IdxW'(1);
        end
        else if (cmd.finish)
        begin
            drain_idx_reg <= drain_idx_reg + 13'd1;
        end
    end

    // datapath payload registers
    logic [16:0] mag;
    assign mag = ram_rdata[DiffW-1] ? 17'(-ram_rdata) : ram_rdata;
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            win_reg   <= drain_win;
            lastf_reg <= stat.drain_last;
        end
        if (cmd.mul)
        begin
            den_reg <= DenW'(energy_reg * cfg_interval);
        end
        if (cmd.div_start)
        begin
            neg_reg <= ram_rdata[DiffW-1];
            zd_reg  <= (den_reg == '0) || (ram_rdata == '0);
            num_reg <= {mag, 47'd0};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r4;
            num_reg <= {num_reg[NumW-5:0], qd};
        end
        if (cmd.finish)
        begin
            residual    <= res_val;
            misfit      <= lastf_reg ? misfit_reg : '0;
            last        <= lastf_reg;
            zero_energy <= (energy_reg == '0);
        end
    end
endmodule : wwmr_datapath
`default_nettype wire

// File: design/wwmr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwmr_ctrl
// sequencer for load and drain transactions and output handshake
// ----------------------------------------------------------------------------
module wwmr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire wwmr_pkg::wwmr_stat_t stat,
    output wwmr_pkg::wwmr_cmd_t       cmd
);
    import wwmr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_START, S_DIV, S_FIN, S_WAIT
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        ov_reg, ov_next;
    logic        fin_last_reg, fin_last_next;

    logic in_fire;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        ov_next       = ov_reg && !out_ready;
        fin_last_next = fin_last_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (operation == 1'b0)
                        cmd.load = 1'b1;
                    else
                    begin
                        cmd.rd     = 1'b1;
                        cmd.mul    = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.div_start = 1'b1;
                fin_last_next = stat.drain_last;
                step_next     = '0;
                state_next    = S_DIV;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 4'd1;
                if (step_reg == 4'd15)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!ov_reg || out_ready)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                cmd.clear  = fin_last_reg;
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            ov_reg       <= 1'b0;
            fin_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            ov_reg       <= ov_next;
            fin_last_reg <= fin_last_next;
        end
    end
endmodule : wwmr_ctrl
`default_nettype wire
